// ===== rtl/ps2_scancode_to_ascii_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// ps2 scancode decoder assertion macros
// Shared assertion wrappers for the scancode decoder checker.
// ----------------------------------------------------------------------------
`ifndef PS2_SCANCODE_TO_ASCII_DECODER_DEFINES_SVH
`define PS2_SCANCODE_TO_ASCII_DECODER_DEFINES_SVH

// checked on every rising edge outside reset
`define PS2KBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every rising edge, reset included
`define PS2KBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/ps2kbd_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2kbd_pkg
// Codes, result kinds and key tables for the scancode set 1 decoder.
// ----------------------------------------------------------------------------
package ps2kbd_pkg;

  localparam int unsigned ScancodeW = 8;
  localparam int unsigned AsciiW    = 7;
  localparam int unsigned KindW     = 3;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 16;
  localparam int unsigned OutPadW   = OutDataW - KindW - AsciiW;

  typedef logic [ScancodeW-1:0] scancode_t;
  typedef logic [AsciiW-1:0]    ascii_t;

  typedef enum logic [KindW-1:0] {
    KIND_CHAR  = 3'd0,
    KIND_UP    = 3'd1,
    KIND_DOWN  = 3'd2,
    KIND_LEFT  = 3'd3,
    KIND_RIGHT = 3'd4
  } key_kind_e;

  localparam scancode_t SC_PREFIX     = 8'hE0;
  localparam scancode_t SC_LSHIFT_MK  = 8'h2A;
  localparam scancode_t SC_RSHIFT_MK  = 8'h36;
  localparam scancode_t SC_LSHIFT_BRK = 8'hAA;
  localparam scancode_t SC_RSHIFT_BRK = 8'hB6;
  localparam scancode_t SC_CAPS       = 8'h3A;
  localparam scancode_t SC_UP         = 8'h48;
  localparam scancode_t SC_DOWN       = 8'h50;
  localparam scancode_t SC_LEFT       = 8'h4B;
  localparam scancode_t SC_RIGHT      = 8'h4D;
  localparam int unsigned BreakBit    = 7;

  localparam ascii_t CaseBit = 7'h20;

  function automatic ascii_t rom_plain(input logic [6:0] idx);
    ascii_t ch;
    unique case (idx)
      7'h01: ch = 7'h1B;  7'h02: ch = 7'h31;  7'h03: ch = 7'h32;  7'h04: ch = 7'h33;
      7'h05: ch = 7'h34;  7'h06: ch = 7'h35;  7'h07: ch = 7'h36;  7'h08: ch = 7'h37;
      7'h09: ch = 7'h38;  7'h0A: ch = 7'h39;  7'h0B: ch = 7'h30;  7'h0C: ch = 7'h2D;
      7'h0D: ch = 7'h3D;  7'h0E: ch = 7'h08;  7'h0F: ch = 7'h09;  7'h10: ch = 7'h71;
      7'h11: ch = 7'h77;  7'h12: ch = 7'h65;  7'h13: ch = 7'h72;  7'h14: ch = 7'h74;
      7'h15: ch = 7'h79;  7'h16: ch = 7'h75;  7'h17: ch = 7'h69;  7'h18: ch = 7'h6F;
      7'h19: ch = 7'h70;  7'h1A: ch = 7'h5B;  7'h1B: ch = 7'h5D;  7'h1C: ch = 7'h0A;
      7'h1E: ch = 7'h61;  7'h1F: ch = 7'h73;  7'h20: ch = 7'h64;  7'h21: ch = 7'h66;
      7'h22: ch = 7'h67;  7'h23: ch = 7'h68;  7'h24: ch = 7'h6A;  7'h25: ch = 7'h6B;
      7'h26: ch = 7'h6C;  7'h27: ch = 7'h3B;  7'h28: ch = 7'h27;  7'h29: ch = 7'h60;
      7'h2B: ch = 7'h5C;  7'h2C: ch = 7'h7A;  7'h2D: ch = 7'h78;  7'h2E: ch = 7'h63;
      7'h2F: ch = 7'h76;  7'h30: ch = 7'h62;  7'h31: ch = 7'h6E;  7'h32: ch = 7'h6D;
      7'h33: ch = 7'h2C;  7'h34: ch = 7'h2E;  7'h35: ch = 7'h2F;  7'h37: ch = 7'h2A;
      7'h39: ch = 7'h20;
      default: ch = '0;
    endcase
    return ch;
  endfunction

  function automatic ascii_t rom_shifted(input logic [6:0] idx);
    ascii_t ch;
    unique case (idx)
      7'h01: ch = 7'h1B;  7'h02: ch = 7'h21;  7'h03: ch = 7'h40;  7'h04: ch = 7'h23;
      7'h05: ch = 7'h24;  7'h06: ch = 7'h25;  7'h07: ch = 7'h5E;  7'h08: ch = 7'h26;
      7'h09: ch = 7'h2A;  7'h0A: ch = 7'h28;  7'h0B: ch = 7'h29;  7'h0C: ch = 7'h5F;
      7'h0D: ch = 7'h2B;  7'h0E: ch = 7'h08;  7'h0F: ch = 7'h09;  7'h10: ch = 7'h51;
      7'h11: ch = 7'h57;  7'h12: ch = 7'h45;  7'h13: ch = 7'h52;  7'h14: ch = 7'h54;
      7'h15: ch = 7'h59;  7'h16: ch = 7'h55;  7'h17: ch = 7'h49;  7'h18: ch = 7'h4F;
      7'h19: ch = 7'h50;  7'h1A: ch = 7'h7B;  7'h1B: ch = 7'h7D;  7'h1C: ch = 7'h0A;
      7'h1E: ch = 7'h41;  7'h1F: ch = 7'h53;  7'h20: ch = 7'h44;  7'h21: ch = 7'h46;
      7'h22: ch = 7'h47;  7'h23: ch = 7'h48;  7'h24: ch = 7'h4A;  7'h25: ch = 7'h4B;
      7'h26: ch = 7'h4C;  7'h27: ch = 7'h3A;  7'h28: ch = 7'h22;  7'h29: ch = 7'h7E;
      7'h2B: ch = 7'h7C;  7'h2C: ch = 7'h5A;  7'h2D: ch = 7'h58;  7'h2E: ch = 7'h43;
      7'h2F: ch = 7'h56;  7'h30: ch = 7'h42;  7'h31: ch = 7'h4E;  7'h32: ch = 7'h4D;
      7'h33: ch = 7'h3C;  7'h34: ch = 7'h3E;  7'h35: ch = 7'h3F;  7'h37: ch = 7'h2A;
      7'h39: ch = 7'h20;
      default: ch = '0;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/ps2_scancode_to_ascii_decoder.sv =====
// ----------------------------------------------------------------------------
// ps2_scancode_to_ascii_decoder
// Turns scancode set 1 bytes into ascii characters and arrow key events.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata fields (lsb first)                | items
//  s_axis   | in  | scancode[7:0]                           | one per byte
//  m_axis   | out | key_kind[2:0], ascii_char[9:3], pad     | zero or one per byte
//
// one item per cycle sustained while m_axis is not stalled; a byte that is
// taken passes the input register, then decode and flag update into the
// result register. reset clears shift, caps, prefix and both valid flags.
// a stalled m_axis holds the result register; the input register still
// takes an item while it is empty or drains in the same cycle.
// ----------------------------------------------------------------------------
module ps2_scancode_to_ascii_decoder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [ps2kbd_pkg::InDataW-1:0]     s_axis_tdata,   // scancode
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [ps2kbd_pkg::OutDataW-1:0]    m_axis_tdata    // key_kind, ascii_char, zero pad
);
  import ps2kbd_pkg::*;

  logic      in_vld_q;
  scancode_t code_q;
  logic      out_vld_q;
  key_kind_e kind_q, kind_d;
  ascii_t    ascii_q, ascii_d;
  logic      shift_q, shift_d;
  logic      caps_q, caps_d;
  logic      prefix_q, prefix_d;
  logic      advance, fire, hit;
  ascii_t    lookup;
  logic      is_letter;

  assign advance       = !out_vld_q || m_axis_tready;
  assign fire          = in_vld_q && advance;
  assign s_axis_tready = !in_vld_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      code_q <= s_axis_tdata[ScancodeW-1:0];
    end
  end

  assign lookup    = shift_q ? rom_shifted(code_q[6:0]) : rom_plain(code_q[6:0]);
  assign is_letter = ((lookup | CaseBit) >= 7'h61) && ((lookup | CaseBit) <= 7'h7A);

  always_comb begin
    shift_d  = shift_q;
    caps_d   = caps_q;
    prefix_d = prefix_q;
    hit      = 1'b0;
    kind_d   = KIND_CHAR;
    ascii_d  = '0;
    if (code_q == SC_PREFIX) begin
      prefix_d = 1'b1;
    end else if (prefix_q) begin
      prefix_d = 1'b0;
      unique case (code_q)
        SC_UP: begin
          hit    = 1'b1;
          kind_d = KIND_UP;
        end
        SC_DOWN: begin
          hit    = 1'b1;
          kind_d = KIND_DOWN;
        end
        SC_LEFT: begin
          hit    = 1'b1;
          kind_d = KIND_LEFT;
        end
        SC_RIGHT: begin
          hit    = 1'b1;
          kind_d = KIND_RIGHT;
        end
        default: ;
      endcase
    end else begin
      case (code_q) inside
        SC_LSHIFT_MK, SC_RSHIFT_MK:   shift_d = 1'b1;
        SC_LSHIFT_BRK, SC_RSHIFT_BRK: shift_d = 1'b0;
        SC_CAPS:                      caps_d  = !caps_q;
        default: begin
          if (!code_q[BreakBit]) begin
            // caps flips letter case, shifted or not
            ascii_d = (caps_q && is_letter) ? (lookup ^ CaseBit) : lookup;
            hit     = (lookup != '0);
          end
        end
      endcase
    end
  end

  // key state, updated once per decoded item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= 1'b0;
      caps_q   <= 1'b0;
      prefix_q <= 1'b0;
    end else if (fire) begin
      shift_q  <= shift_d;
      caps_q   <= caps_d;
      prefix_q <= prefix_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= fire && hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && hit) begin
      kind_q  <= kind_d;
      ascii_q <= ascii_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{OutPadW{1'b0}}, ascii_q, kind_q};

endmodule

// ===== rtl/ps2kbd_checker.sv =====
// ----------------------------------------------------------------------------
// ps2kbd_checker
// Port level checks for the scancode decoder, bound into the decoder module.
// ----------------------------------------------------------------------------
`include "ps2_scancode_to_ascii_decoder_defines.svh"

module ps2kbd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ps2kbd_pkg::OutDataW-1:0] m_axis_tdata
);
  import ps2kbd_pkg::*;

  logic   s_fire;
  logic   is_char;
  ascii_t out_ascii;

  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign is_char   = (m_axis_tdata[KindW-1:0] == KIND_CHAR);
  assign out_ascii = m_axis_tdata[KindW+AsciiW-1:KindW];

  // no result item is visible after reset has been sampled low
  `PS2KBD_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |=> !m_axis_tvalid, "result during reset")

  // a new result always comes from an item taken on the input, through the input and result registers
  `PS2KBD_ASSERT(a_latency, $rose(m_axis_tvalid) |-> $past(s_fire, 2), "result without input item")

  // arrows carry no character and characters are never nul
  `PS2KBD_ASSERT(a_payload, m_axis_tvalid |-> (is_char ? (out_ascii != '0) : (out_ascii == '0)), "bad payload")

  // a stalled result holds
  `PS2KBD_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind ps2_scancode_to_ascii_decoder ps2kbd_checker u_ps2kbd_checker (.*);

// ===== dv/ps2_scancode_to_ascii_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// ps2_scancode_to_ascii_decoder_tb
// Streams scancode set 1 bytes into the decoder and checks every key item
// against a behavioral keyboard model kept in a small scoreboard. Directed
// bytes cover the table ends, shift, caps and prefix corner cases; random
// typing sessions follow under several sender and receiver idling mixes,
// with one long receiver hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
module ps2_scancode_to_ascii_decoder_tb;
  import ps2kbd_pkg::*;

  localparam int unsigned KeyMapDepth  = 58;
  localparam int unsigned PhaseItems   = 475;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned HoldCycles   = 80;
  localparam int unsigned MaxReports   = 50;

  // key maps for make codes 00..39, everything above maps to zero
  localparam ascii_t PlainMap [KeyMapDepth] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };
  localparam ascii_t ShiftMap [KeyMapDepth] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  typedef struct packed {
    key_kind_e kind;
    ascii_t    ch;
  } key_event_t;

  class key_scoreboard;
    bit         shift_held;
    bit         caps_on;
    bit         prefix_seen;
    key_event_t pending[$];
    int unsigned errors;
    int unsigned reports;

    function void push_key(key_kind_e kind, ascii_t ch);
      key_event_t ev;
      ev.kind = kind;
      ev.ch   = ch;
      pending.push_back(ev);
    endfunction

    // run one accepted byte through the keyboard model
    function void note_scancode(scancode_t code);
      ascii_t ch;
      if (code == SC_PREFIX) begin
        prefix_seen = 1'b1;
        return;
      end
      if (prefix_seen) begin
        prefix_seen = 1'b0;
        case (code)
          SC_UP:    push_key(KIND_UP, '0);
          SC_DOWN:  push_key(KIND_DOWN, '0);
          SC_LEFT:  push_key(KIND_LEFT, '0);
          SC_RIGHT: push_key(KIND_RIGHT, '0);
          default:  ;
        endcase
        return;
      end
      if (code == SC_LSHIFT_MK || code == SC_RSHIFT_MK) begin
        shift_held = 1'b1;
        return;
      end
      if (code == SC_LSHIFT_BRK || code == SC_RSHIFT_BRK) begin
        shift_held = 1'b0;
        return;
      end
      if (code == SC_CAPS) begin
        caps_on = !caps_on;
        return;
      end
      if (code[BreakBit]) return;
      if (code >= KeyMapDepth) ch = '0;
      else ch = shift_held ? ShiftMap[code] : PlainMap[code];
      // caps flips letters only; with shift it brings them back to lower case
      if (caps_on && ch >= 7'h61 && ch <= 7'h7A) begin
        ch = ch - CaseBit;
      end else if (caps_on && shift_held && ch >= 7'h41 && ch <= 7'h5A) begin
        ch = ch + CaseBit;
      end
      if (ch != '0) push_key(KIND_CHAR, ch);
    endfunction

    function void report(string what, int unsigned exp_val, int unsigned act_val);
      errors++;
      if (reports < MaxReports) begin
        reports++;
        $display("%0t: %s expected %0h actual %0h", $time, what, exp_val, act_val);
      end
    endfunction

    function void check_key(logic [OutDataW-1:0] tdata);
      key_event_t ev;
      logic [KindW-1:0]   got_kind;
      ascii_t             got_ch;
      logic [OutPadW-1:0] got_pad;
      got_kind = tdata[KindW-1:0];
      got_ch   = tdata[KindW +: AsciiW];
      got_pad  = tdata[OutDataW-1 -: OutPadW];
      if (pending.size() == 0) begin
        report("unexpected key item, tdata", 0, tdata);
        return;
      end
      ev = pending.pop_front();
      if (got_kind != ev.kind) report("key_kind", ev.kind, got_kind);
      if (got_ch != ev.ch) report("ascii_char", ev.ch, got_ch);
      if (got_pad != '0) report("pad", 0, got_pad);
    endfunction

    function bit drained();
      return pending.size() == 0;
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;   // scancode[7:0]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;         // key_kind[2:0], ascii_char[9:3], pad

  key_scoreboard sb;
  int unsigned   send_idle_pct;
  int unsigned   recv_stall_pct;
  int unsigned   hold_request;
  int unsigned   hold_left;
  int unsigned   sent_count;
  int unsigned   quiet_cycles;

  ps2_scancode_to_ascii_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // result side: check accepted items, then pick the next tready
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_key(m_axis_tdata);
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("ps2_scancode_to_ascii_decoder: mismatch");
        $finish;
      end
    end
  end

  task automatic send_scancode(input scancode_t code);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_scancode(code);
    sent_count++;
  endtask

  task automatic type_random_keys();
    int unsigned pick;
    scancode_t   key;
    pick = $urandom_range(0, 99);
    key  = scancode_t'($urandom_range(1, KeyMapDepth - 1));
    if (pick < 45) begin
      send_scancode(key);
      if ($urandom_range(0, 3) != 0) send_scancode(key | 8'h80);
    end else if (pick < 55) begin
      send_scancode($urandom_range(0, 1) ? SC_LSHIFT_MK : SC_RSHIFT_MK);
    end else if (pick < 63) begin
      send_scancode($urandom_range(0, 1) ? SC_LSHIFT_BRK : SC_RSHIFT_BRK);
    end else if (pick < 67) begin
      send_scancode(SC_CAPS);
    end else if (pick < 77) begin
      send_scancode(SC_PREFIX);
      case ($urandom_range(0, 3))
        0:       send_scancode(SC_UP);
        1:       send_scancode(SC_DOWN);
        2:       send_scancode(SC_LEFT);
        default: send_scancode(SC_RIGHT);
      endcase
    end else if (pick < 80) begin
      send_scancode(SC_PREFIX);
      send_scancode(scancode_t'($urandom_range(0, 255)));
    end else if (pick < 82) begin
      send_scancode(SC_PREFIX);
      send_scancode(SC_PREFIX);
      send_scancode(SC_LEFT);
    end else if (pick < 85) begin
      send_scancode(SC_CAPS | 8'h80);
    end else begin
      send_scancode(scancode_t'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    scancode_t directed[$];
    int unsigned phase;
    int unsigned phase_start;
    sb = new();
    directed = '{
      8'h00, 8'h01, 8'h39, 8'hFF,
      SC_LSHIFT_MK, 8'h1E, SC_CAPS, 8'h1E, 8'h02, SC_LSHIFT_BRK, 8'h1E,
      SC_CAPS | 8'h80, SC_CAPS,
      SC_PREFIX, SC_UP, SC_PREFIX, SC_DOWN, SC_PREFIX, SC_PREFIX, SC_LEFT,
      SC_PREFIX, SC_RIGHT,
      // prefixed shift and caps must leave the flags alone
      SC_PREFIX, SC_LSHIFT_MK, 8'h1E, SC_PREFIX, SC_CAPS, 8'h1E
    };
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_scancode(directed[i]);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      // back the pipeline up while the sender keeps offering bytes
      if (phase == 0) hold_request = HoldCycles;
      phase_start = sent_count;
      while (sent_count - phase_start < PhaseItems) type_random_keys();
    end
    s_axis_tvalid <= 1'b0;

    while (!sb.drained()) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.drained()) begin
      $display("ps2_scancode_to_ascii_decoder: match");
    end else begin
      $display("ps2_scancode_to_ascii_decoder: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ps2kbd_pkg.sv
rtl/ps2_scancode_to_ascii_decoder.sv
rtl/ps2kbd_checker.sv
dv/ps2_scancode_to_ascii_decoder_tb.sv
